>>> hdl/tsds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-stage divisor search.
package tsds_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;
  localparam int TARGET_W    = 31;
  localparam int STATUS_W    = 2;
  localparam int MAIN_OUT_W  = 9;
  localparam int FINE_OUT_W  = 16;
  localparam int MAIN_BITS_W = 4;
  localparam int FINE_BITS_W = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAIN_BITS   = 2'd0,
    CFG_FINE_BITS   = 2'd1,
    CFG_SOURCE_RATE = 2'd2
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_PASS  = 2'd1,
    ST_NONE  = 2'd2
  } status_t;

  localparam logic [MAIN_BITS_W-1:0] MAIN_BITS_RST   = 4'd4;
  localparam logic [FINE_BITS_W-1:0] FINE_BITS_RST   = 5'd8;
  localparam logic [CFG_DATA_W-1:0]  SOURCE_RATE_RST = 31'd400000000;

endpackage

>>> hdl/tsds_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, two quotient bits per cycle.
module tsds_div #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient
);

  localparam int DW    = WIDTH + (WIDTH % 2);
  localparam int STEPS = DW / 2;
  localparam int CNTW  = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [DW-1:0]    quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] div_r;
  logic [CNTW-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;

  always_comb begin
    logic [WIDTH:0] trial;
    logic [WIDTH:0] diff;
    logic           ge;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_nxt, quo_nxt[DW-1]};
      diff  = trial - {1'b0, div_r};
      ge    = (trial >= {1'b0, div_r});
      rem_nxt = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_nxt = {quo_nxt[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= DW'(dividend);
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[WIDTH-1:0];

endmodule

>>> hdl/two_stage_divisor_search.sv
`timescale 1ns / 1ps
// Two-stage divisor search: one shared divider under a small sequencer.
// Zero and passthrough cases go straight from S_IDLE to S_DONE; a full search takes 2^mb
// trials of three divisions each on the divider (31 bits wide by default). S_DONE loads the
// output register once the output is free, and out_valid follows from that register.
// One transaction at a time: in_stall stays high until the sequencer returns to S_IDLE.
// Reset (synchronous, rst_n low): idle, no result pending, registers at defaults.
module two_stage_divisor_search #(
  parameter int MAX_MAIN_BITS = 8,
  parameter int MAX_FINE_BITS = 16,
  parameter int RATE_WIDTH    = 31
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tsds_pkg::TARGET_W-1:0]    in_target_rate,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tsds_pkg::STATUS_W-1:0]    out_status,
  output logic [tsds_pkg::MAIN_OUT_W-1:0]  out_main_divisor,
  output logic [tsds_pkg::FINE_OUT_W-1:0]  out_fine_divisor,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tsds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsds_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int RW   = RATE_WIDTH;
  localparam int MW   = MAX_MAIN_BITS + 1;
  localparam int FW   = MAX_FINE_BITS;
  localparam int DIVW = (RW > MW) ? RW : MW;
  localparam int CMPW = (DIVW > FW) ? DIVW : FW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DQ   = 5'b00010,
    S_DF   = 5'b00100,
    S_DR   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [tsds_pkg::MAIN_BITS_W-1:0] main_bits_r;
  logic [tsds_pkg::FINE_BITS_W-1:0] fine_bits_r;
  logic [RW-1:0]                    source_r;

  logic [RW-1:0] target_r, target_nxt;
  logic [RW-1:0] q_r, q_nxt;
  logic [RW-1:0] best_err_r, best_err_nxt;
  logic [MW-1:0] m_r, m_nxt;
  logic [MW-1:0] last_m_r, last_m_nxt;
  logic [MW-1:0] best_main_r, best_main_nxt;
  logic [FW-1:0] best_fine_r, best_fine_nxt;
  logic [FW-1:0] cap_r, cap_nxt;
  logic          kept_r, kept_nxt;

  tsds_pkg::status_t res_status_r, res_status_nxt;
  logic [MW-1:0]     res_main_r, res_main_nxt;
  logic [FW-1:0]     res_fine_r, res_fine_nxt;

  logic                          out_valid_r;
  tsds_pkg::status_t             out_status_r;
  logic [tsds_pkg::MAIN_OUT_W-1:0] out_main_r;
  logic [tsds_pkg::FINE_OUT_W-1:0] out_fine_r;
  logic                          out_load;

  logic            div_start;
  logic [DIVW-1:0] div_dividend;
  logic [DIVW-1:0] div_divisor;
  logic            div_done;
  logic [DIVW-1:0] div_quo;

  logic [RW-1:0] in_target;
  logic [4:0]    mb_eff;
  logic [4:0]    fb_eff;
  logic [FW:0]   cap_sh;
  logic [FW-1:0] fine_c;
  logic [RW-1:0] rate_c;
  logic [RW-1:0] err_c;
  logic          trial_ok;

  tsds_div #(
    .WIDTH(DIVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_target = RW'(in_target_rate);
  assign mb_eff = ({1'b0, main_bits_r} > 5'(MAX_MAIN_BITS)) ? 5'(MAX_MAIN_BITS)
                                                            : {1'b0, main_bits_r};
  assign fb_eff = (fine_bits_r > 5'(MAX_FINE_BITS)) ? 5'(MAX_FINE_BITS) : fine_bits_r;
  assign cap_sh = (FW + 1)'(1) << fb_eff;

  always_comb begin
    logic [FW-1:0] f_clamp;
    f_clamp = (CMPW'(div_quo) > CMPW'(cap_r)) ? cap_r : FW'(div_quo);
    fine_c  = (f_clamp == '0) ? FW'(1) : f_clamp;
  end

  assign rate_c   = RW'(div_quo);
  assign err_c    = target_r - rate_c;
  assign trial_ok = (rate_c <= target_r) && (err_c <= best_err_r);

  always_comb begin
    state_nxt      = state_r;
    target_nxt     = target_r;
    q_nxt          = q_r;
    best_err_nxt   = best_err_r;
    m_nxt          = m_r;
    last_m_nxt     = last_m_r;
    best_main_nxt  = best_main_r;
    best_fine_nxt  = best_fine_r;
    cap_nxt        = cap_r;
    kept_nxt       = kept_r;
    res_status_nxt = res_status_r;
    res_main_nxt   = res_main_r;
    res_fine_nxt   = res_fine_r;
    div_start      = 1'b0;
    div_dividend   = DIVW'(source_r);
    div_divisor    = DIVW'(1);
    out_load       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          target_nxt = in_target;
          if (source_r == '0 || in_target == '0) begin
            res_status_nxt = tsds_pkg::ST_NONE;
            res_main_nxt   = '0;
            res_fine_nxt   = FW'(1);
            state_nxt      = S_DONE;
          end else if (in_target >= source_r) begin
            res_status_nxt = tsds_pkg::ST_PASS;
            res_main_nxt   = MW'(1);
            res_fine_nxt   = FW'(1);
            state_nxt      = S_DONE;
          end else begin
            m_nxt         = MW'(1);
            last_m_nxt    = MW'(1) << mb_eff;
            cap_nxt       = cap_sh[FW-1:0] - FW'(1);
            best_err_nxt  = in_target;
            best_main_nxt = '0;
            best_fine_nxt = FW'(1);
            kept_nxt      = 1'b0;
            div_start     = 1'b1;
            div_dividend  = DIVW'(source_r);
            div_divisor   = DIVW'(1);
            state_nxt     = S_DQ;
          end
        end
      end
      S_DQ: begin
        if (div_done) begin
          q_nxt        = RW'(div_quo);
          div_start    = 1'b1;
          div_dividend = div_quo;
          div_divisor  = DIVW'(target_r);
          state_nxt    = S_DF;
        end
      end
      S_DF: begin
        if (div_done) begin
          best_fine_nxt = best_fine_r;
          div_start     = 1'b1;
          div_dividend  = DIVW'(q_r);
          div_divisor   = DIVW'(fine_c);
          cap_nxt       = cap_r;
          res_fine_nxt  = fine_c;
          state_nxt     = S_DR;
        end
      end
      S_DR: begin
        if (div_done) begin
          if (trial_ok) begin
            best_err_nxt  = err_c;
            best_main_nxt = m_r;
            best_fine_nxt = res_fine_r;
            kept_nxt      = 1'b1;
          end
          if (m_r == last_m_r) begin
            if (kept_nxt) begin
              res_status_nxt = tsds_pkg::ST_FOUND;
              res_main_nxt   = best_main_nxt;
              res_fine_nxt   = best_fine_nxt;
            end else begin
              res_status_nxt = tsds_pkg::ST_NONE;
              res_main_nxt   = '0;
              res_fine_nxt   = FW'(1);
            end
            state_nxt = S_DONE;
          end else begin
            m_nxt        = m_r + MW'(1);
            div_start    = 1'b1;
            div_dividend = DIVW'(source_r);
            div_divisor  = DIVW'(m_nxt);
            state_nxt    = S_DQ;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      main_bits_r <= tsds_pkg::MAIN_BITS_RST;
      fine_bits_r <= tsds_pkg::FINE_BITS_RST;
      source_r    <= RW'(tsds_pkg::SOURCE_RATE_RST);
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          tsds_pkg::CFG_MAIN_BITS:   main_bits_r <= cfg_data[tsds_pkg::MAIN_BITS_W-1:0];
          tsds_pkg::CFG_FINE_BITS:   fine_bits_r <= cfg_data[tsds_pkg::FINE_BITS_W-1:0];
          tsds_pkg::CFG_SOURCE_RATE: source_r    <= RW'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    target_r     <= target_nxt;
    q_r          <= q_nxt;
    best_err_r   <= best_err_nxt;
    m_r          <= m_nxt;
    last_m_r     <= last_m_nxt;
    best_main_r  <= best_main_nxt;
    best_fine_r  <= best_fine_nxt;
    cap_r        <= cap_nxt;
    kept_r       <= kept_nxt;
    res_status_r <= res_status_nxt;
    res_main_r   <= res_main_nxt;
    res_fine_r   <= res_fine_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_main_r   <= tsds_pkg::MAIN_OUT_W'(res_main_r);
      out_fine_r   <= tsds_pkg::FINE_OUT_W'(res_fine_r);
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_main_divisor = out_main_r;
  assign out_fine_divisor = out_fine_r;

endmodule

>>> dv/two_stage_divisor_search_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-stage divisor search: directed, random and back-pressure.
module two_stage_divisor_search_tb;

  localparam int MAX_MAIN = 8;
  localparam int MAX_FINE = 16;
  localparam int RATE_W = 31;
  localparam int HOLD_CYCLES = 3000;
  localparam int LIMIT_CYCLES = 30000000;
  localparam int TAIL_CYCLES = 20;
  localparam logic [tsds_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  typedef struct packed {
    tsds_pkg::status_t                status;
    logic [tsds_pkg::MAIN_OUT_W-1:0]  main_div;
    logic [tsds_pkg::FINE_OUT_W-1:0]  fine_div;
  } divisors_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [tsds_pkg::TARGET_W-1:0] in_target_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [tsds_pkg::STATUS_W-1:0] out_status;
  logic [tsds_pkg::MAIN_OUT_W-1:0] out_main_divisor;
  logic [tsds_pkg::FINE_OUT_W-1:0] out_fine_divisor;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tsds_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tsds_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [tsds_pkg::MAIN_BITS_W-1:0] model_main_bits = tsds_pkg::MAIN_BITS_RST;
  logic [tsds_pkg::FINE_BITS_W-1:0] model_fine_bits = tsds_pkg::FINE_BITS_RST;
  logic [RATE_W-1:0] model_source_rate = tsds_pkg::SOURCE_RATE_RST;

  divisors_t pending_divisors[$];
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  two_stage_divisor_search #(
    .MAX_MAIN_BITS(MAX_MAIN),
    .MAX_FINE_BITS(MAX_FINE),
    .RATE_WIDTH(RATE_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_target_rate(in_target_rate),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_main_divisor(out_main_divisor),
    .out_fine_divisor(out_fine_divisor),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic divisors_t predict_divisors(input logic [RATE_W-1:0] target);
    divisors_t r;
    logic [31:0] src, tgt, q, fine, rate, err, best_err, cap, mm;
    int mb, fb, loops;
    bit kept;
    r.status = tsds_pkg::ST_NONE;
    r.main_div = '0;
    r.fine_div = 16'd1;
    src = {1'b0, model_source_rate};
    tgt = {1'b0, target};
    if (src != 0 && tgt != 0) begin
      if (tgt >= src) begin
        r.status = tsds_pkg::ST_PASS;
        r.main_div = 9'd1;
      end else begin
        mb = (model_main_bits > MAX_MAIN) ? MAX_MAIN : int'(model_main_bits);
        fb = (model_fine_bits > MAX_FINE) ? MAX_FINE : int'(model_fine_bits);
        cap = (32'd1 << fb) - 32'd1;
        loops = 1 << mb;
        best_err = tgt;
        kept = 1'b0;
        for (int m = 1; m <= loops; m++) begin
          mm = m;
          q = src / mm;
          fine = q / tgt;
          if (fine > cap) fine = cap;
          if (fine < 32'd1) fine = 32'd1;
          rate = q / fine;
          if (rate <= tgt) begin
            err = tgt - rate;
            if (err <= best_err) begin
              best_err = err;
              r.main_div = mm[tsds_pkg::MAIN_OUT_W-1:0];
              r.fine_div = fine[tsds_pkg::FINE_OUT_W-1:0];
              kept = 1'b1;
            end
          end
        end
        if (kept) begin
          r.status = tsds_pkg::ST_FOUND;
        end else begin
          r.main_div = '0;
          r.fine_div = 16'd1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, exp_v);
    errors++;
  endtask

  // input transaction monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0) begin
      pending_divisors.push_back(predict_divisors(in_target_rate));
    end
  end

  // result checker
  always @(posedge clk) begin
    divisors_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_divisors.size() == 0) begin
        report_mismatch("result with nothing pending", out_status, -1);
      end else begin
        exp_r = pending_divisors.pop_front();
        if (out_status !== exp_r.status)
          report_mismatch("status", out_status, exp_r.status);
        if (out_main_divisor !== exp_r.main_div)
          report_mismatch("main_divisor", out_main_divisor, exp_r.main_div);
        if (out_fine_divisor !== exp_r.fine_div)
          report_mismatch("fine_divisor", out_fine_divisor, exp_r.fine_div);
      end
    end
  end

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    hold_seen <= hold_tog;
    if (hold_tog != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("two_stage_divisor_search verification failed");
      $finish;
    end
  end

  task automatic send_target(input logic [RATE_W-1:0] target);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 30) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_rate <= target;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_divisors.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tsds_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [tsds_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      tsds_pkg::CFG_MAIN_BITS:   model_main_bits = data[tsds_pkg::MAIN_BITS_W-1:0];
      tsds_pkg::CFG_FINE_BITS:   model_fine_bits = data[tsds_pkg::FINE_BITS_W-1:0];
      tsds_pkg::CFG_SOURCE_RATE: model_source_rate = data[RATE_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_target('0);
    send_target(RATE_MAX);
    send_target(tsds_pkg::SOURCE_RATE_RST);
    send_target(tsds_pkg::SOURCE_RATE_RST - 1);
    send_target(31'd1);
    send_target(31'd33000000);
    send_target(31'd24000000);
    send_target(31'd100000000);
    wait_results_done();
  endtask

  task automatic test_register_extremes();
    // fine width zero, main wider than fine
    write_reg(tsds_pkg::CFG_FINE_BITS, 31'd0);
    send_target(31'd33000000);
    send_target(31'd1000000);
    wait_results_done();
    write_reg(tsds_pkg::CFG_MAIN_BITS, 31'd0);
    send_target(31'd33000000);
    send_target(31'd150000000);
    wait_results_done();
    // widths beyond their maxima
    write_reg(tsds_pkg::CFG_FINE_BITS, 31'd31);
    write_reg(tsds_pkg::CFG_MAIN_BITS, 31'd15);
    send_target(31'd1000000);
    send_target(31'd7);
    wait_results_done();
    write_reg(tsds_pkg::CFG_MAIN_BITS, 31'd1);
    write_reg(tsds_pkg::CFG_FINE_BITS, 31'd16);
    send_target(31'd100);
    send_target(31'd3000000);
    wait_results_done();
    write_reg(tsds_pkg::CFG_SOURCE_RATE, 31'd0);
    send_target('0);
    send_target(31'd12345);
    wait_results_done();
    write_reg(tsds_pkg::CFG_SOURCE_RATE, RATE_MAX);
    write_reg(CFG_UNUSED, 31'($urandom));
    send_target(RATE_MAX);
    send_target(RATE_MAX - 1);
    send_target(31'd1000000007);
    wait_results_done();
  endtask

  task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
    int sent, group_len, mb_eff;
    logic [tsds_pkg::CFG_DATA_W-1:0] d;
    logic [31:0] src, tgt;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      d = $urandom_range(1) ? 31'($urandom) : 31'd0;
      d[tsds_pkg::MAIN_BITS_W-1:0] = ($urandom_range(15) == 0) ? 4'($urandom_range(15))
                                                               : 4'($urandom_range(3));
      write_reg(tsds_pkg::CFG_MAIN_BITS, d);
      d = $urandom_range(1) ? 31'($urandom) : 31'd0;
      d[tsds_pkg::FINE_BITS_W-1:0] = 5'($urandom_range(31));
      write_reg(tsds_pkg::CFG_FINE_BITS, d);
      case ($urandom_range(15))
        0:       d = '0;
        1:       d = RATE_MAX;
        2, 3, 4, 5, 6, 7, 8: d = 31'($urandom);
        default: d = 31'($urandom_range(800000000, 1000000));
      endcase
      write_reg(tsds_pkg::CFG_SOURCE_RATE, d);
      if ($urandom_range(7) == 0) write_reg(CFG_UNUSED, 31'($urandom));
      mb_eff = (model_main_bits > MAX_MAIN) ? MAX_MAIN : int'(model_main_bits);
      group_len = (mb_eff >= 6) ? 3 : 10;
      src = {1'b0, model_source_rate};
      repeat (group_len) begin
        case ($urandom_range(15))
          0:       tgt = 0;
          1:       tgt = $urandom;
          2:       tgt = src;
          3:       tgt = (src != 0) ? src - 1 : 0;
          4:       tgt = $urandom_range(1000, 1);
          default: tgt = src / $urandom_range(2000, 1) + $urandom_range(3);
        endcase
        send_target(tgt[RATE_W-1:0]);
        sent++;
      end
      wait_results_done();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(tsds_pkg::CFG_MAIN_BITS, 31'd1);
    write_reg(tsds_pkg::CFG_FINE_BITS, 31'd8);
    write_reg(tsds_pkg::CFG_SOURCE_RATE, tsds_pkg::SOURCE_RATE_RST);
    hold_tog <= ~hold_tog;
    send_target(31'd500000000);
    send_target('0);
    send_target(31'd33000000);
    send_target(31'd400000000);
    send_target(31'd12000000);
    send_target(31'd1);
    send_target(31'd90000000);
    send_target(RATE_MAX);
    wait_results_done();
    // sender pauses until every result is back, then carries on
    send_idle_pct = 27;
    recv_idle_pct = 27;
    repeat (4) send_target(31'($urandom_range(200000000, 1)));
    wait_results_done();
    repeat (4) send_target(31'($urandom_range(200000000, 1)));
    wait_results_done();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_backpressure();
    test_random_traffic(165, 27, 88);
    test_random_traffic(165, 88, 27);
    test_random_traffic(170, 0, 0);
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_divisors.size() != 0)
      report_mismatch("results never arrived", pending_divisors.size(), 0);
    if (errors == 0) begin
      $display("two_stage_divisor_search verification clean");
    end else begin
      $display("two_stage_divisor_search verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tsds_pkg.sv
hdl/tsds_div.sv
hdl/two_stage_divisor_search.sv
dv/two_stage_divisor_search_tb.sv
